FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of the range sensor poll sequencer.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define RSPS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's standard clock and reset names.
`define RSPS_ASSERT(lbl, prop, msg) \
    `RSPS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: design/rsps_pkg.sv
// Package for the range sensor poll sequencer: codes, reset values and word types.
// No dependencies; imported by every module of the block.
package rsps_pkg;

    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_CONT = 2'd1;
    localparam logic [1:0] MODE_SHOT = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_INIT_DLY  = 2'd3;

    localparam logic [15:0] RST_THRESHOLD = 16'd200;
    localparam logic [15:0] RST_INTERVAL  = 16'd20;
    localparam logic [15:0] RST_TIMEOUT   = 16'd100;
    localparam logic [15:0] RST_INIT_DLY  = 16'd50;

    localparam logic [7:0] NO_ANSWER  = 8'hFF;
    localparam logic [2:0] READY_MASK = 3'h7;
    localparam int unsigned STALE_FACTOR = 5;
    localparam logic DONE_BIT = 1'b1;

    typedef struct packed {
        logic [15:0] threshold_mm;
        logic [15:0] interval_ms;
        logic [15:0] timeout_ms;
        logic [15:0] init_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        init_ok;
        logic [7:0]  status_byte;
        logic [15:0] range_mm;
        logic        read_timed_out;
    } t_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic        start_continuous;
        logic        start_shot;
        logic        clear_interrupt;
        logic        distance_valid;
        logic [15:0] distance_mm;
        logic        override_on;
    } t_result;

endpackage

FILE: design/rsps_cfg.sv
// Configuration register file of the range sensor poll sequencer.
// Depends on rsps_pkg.
module rsps_cfg
    import rsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_mm  <= RST_THRESHOLD;
            r_cfg.interval_ms   <= RST_INTERVAL;
            r_cfg.timeout_ms    <= RST_TIMEOUT;
            r_cfg.init_delay_ms <= RST_INIT_DLY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_cfg.threshold_mm  <= i_cfg_data;
                REG_INTERVAL:  r_cfg.interval_ms   <= i_cfg_data;
                REG_TIMEOUT:   r_cfg.timeout_ms    <= i_cfg_data;
                REG_INIT_DLY:  r_cfg.init_delay_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/rsps_core.sv
// Sequencer state and per-word decision logic of the range sensor poll sequencer.
// Depends on rsps_pkg.
module rsps_core
    import rsps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    logic [1:0]  r_mode, n_mode;
    logic        r_pending, n_pending;
    logic [31:0] r_poll_t, n_poll_t;
    logic [31:0] r_shot_t, n_shot_t;
    logic [31:0] r_read_t, n_read_t;
    logic [15:0] r_dist, n_dist;
    logic        r_held, n_held;
    logic        r_ovr, n_ovr;

    logic        go_cont, go_shot, clr, take, ready;
    logic [31:0] since_poll, since_shot, since_read;
    logic [18:0] stale_lim;

    assign ready = (i_item.status_byte != NO_ANSWER) &&
                   ((i_item.status_byte[2:0] & READY_MASK) != 3'd0);
    assign since_poll = i_item.now_ms - r_poll_t;
    assign since_shot = i_item.now_ms - r_shot_t;
    // x5 as shift and add
    assign stale_lim  = {i_cfg.timeout_ms, 2'b00} + {3'b000, i_cfg.timeout_ms};

    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_poll_t  = r_poll_t;
        n_shot_t  = r_shot_t;
        n_read_t  = r_read_t;
        n_dist    = r_dist;
        n_held    = r_held;
        n_ovr     = r_ovr;
        go_cont   = 1'b0;
        go_shot   = 1'b0;
        clr       = 1'b0;
        take      = 1'b0;
        since_read = 32'd0;
        priority if (r_mode == MODE_INIT) begin
            if (i_item.now_ms >= {16'd0, i_cfg.init_delay_ms}) begin
                n_mode   = i_item.init_ok ? MODE_CONT : MODE_SHOT;
                go_cont  = i_item.init_ok;
                n_read_t = i_item.now_ms;
            end
        end else if (since_poll >= {16'd0, i_cfg.interval_ms}) begin
            n_poll_t = i_item.now_ms;
            priority if (r_mode == MODE_CONT) begin
                take = ready && !i_item.read_timed_out;
            end else if (!r_pending) begin
                go_shot   = 1'b1;
                n_pending = 1'b1;
                n_shot_t  = i_item.now_ms;
            end else if (ready) begin
                clr       = DONE_BIT;
                n_pending = 1'b0;
                take      = 1'b1;
            end else if (since_shot > {16'd0, i_cfg.timeout_ms}) begin
                n_pending = 1'b0;
            end
            if (take) begin
                n_dist   = i_item.range_mm;
                n_held   = 1'b1;
                n_ovr    = i_item.range_mm < i_cfg.threshold_mm;
                n_read_t = i_item.now_ms;
            end
            since_read = i_item.now_ms - n_read_t;
            if (since_read > {13'd0, stale_lim}) begin
                n_held = 1'b0;
                n_ovr  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INIT;
            r_pending <= 1'b0;
            r_poll_t  <= 32'd0;
            r_shot_t  <= 32'd0;
            r_read_t  <= 32'd0;
            r_dist    <= 16'd0;
            r_held    <= 1'b0;
            r_ovr     <= 1'b0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_poll_t  <= n_poll_t;
            r_shot_t  <= n_shot_t;
            r_read_t  <= n_read_t;
            r_dist    <= n_dist;
            r_held    <= n_held;
            r_ovr     <= n_ovr;
        end
    end

    assign o_result.mode             = n_mode;
    assign o_result.start_continuous = go_cont;
    assign o_result.start_shot       = go_shot;
    assign o_result.clear_interrupt  = clr;
    assign o_result.distance_valid   = n_held;
    assign o_result.distance_mm      = n_held ? n_dist : 16'd0;
    assign o_result.override_on      = n_ovr;

endmodule

FILE: design/range_sensor_poll_sequencer_unit.sv
// Top level of the range sensor poll sequencer: input word register, result register.
// Depends on rsps_pkg, rsps_cfg and rsps_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one time word: the current
//   millisecond time plus the sensor bus answers for that tick. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result word per input word,
//   in order: mode, start/clear pulses and the held distance with its flags.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   0 threshold, 1 poll interval, 2 shot timeout, 3 init delay; write only
//   while no word is in flight.
// Path: an accepted word is held in the input register, then passes through
//   the decision logic into the result register, from which it can be taken.
// Throughput: one word per cycle while the output is not stalled; the sequencer
//   state updates as the word moves between the registers, so the next word sees it.
// Reset: synchronous, active low; empties both registers, config returns to
//   its defaults and the sequencer goes back to not initialised.
// Stall: while the receiver stalls a full result register, the word in the
//   input register waits; o_in_stall rises only if that register is also full.
module range_sensor_poll_sequencer_unit
    import rsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_ms,
    input  logic        i_init_ok,
    input  logic [7:0]  i_status_byte,
    input  logic [15:0] i_range_mm,
    input  logic        i_read_timed_out,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_mode,
    output logic        o_start_continuous,
    output logic        o_start_shot,
    output logic        o_clear_interrupt,
    output logic        o_distance_valid,
    output logic [15:0] o_distance_mm,
    output logic        o_override_on
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    adv;

    rsps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Result register can take a word when empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    rsps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (result)
    );

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.now_ms         <= i_now_ms;
            r_in.init_ok        <= i_init_ok;
            r_in.status_byte    <= i_status_byte;
            r_in.range_mm       <= i_range_mm;
            r_in.read_timed_out <= i_read_timed_out;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_mode             = r_out.mode;
    assign o_start_continuous = r_out.start_continuous;
    assign o_start_shot       = r_out.start_shot;
    assign o_clear_interrupt  = r_out.clear_interrupt;
    assign o_distance_valid   = r_out.distance_valid;
    assign o_distance_mm      = r_out.distance_mm;
    assign o_override_on      = r_out.override_on;

endmodule

FILE: design/rsps_chk.sv
// Port-level checker for range_sensor_poll_sequencer_unit, bound to the top level.
// Depends on rsps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsps_chk
    import rsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_mode,
    input  logic        o_start_continuous,
    input  logic        o_start_shot,
    input  logic        o_distance_valid,
    input  logic [15:0] o_distance_mm,
    input  logic        o_override_on
);

    `RSPS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped")
    `RSPS_ASSERT(a_one_start, o_out_valid |-> !(o_start_continuous && o_start_shot), "two starts")
    `RSPS_ASSERT(a_cont_mode, o_out_valid && o_start_continuous |-> o_mode == MODE_CONT, "bad mode")
    `RSPS_ASSERT(a_ovr_valid, o_out_valid && o_override_on |-> o_distance_valid, "override alone")
    `RSPS_ASSERT(a_dist_zero, o_out_valid && !o_distance_valid |-> o_distance_mm == 16'd0, "stale mm")

endmodule

bind range_sensor_poll_sequencer_unit rsps_chk u_rsps_chk (.*);
